// ----- sv/alu8_pkg.sv -----
// Package for the eight-bit ALU with condition flags.
// Holds the opcode codes, the flag record and the widths shared by all files.
// No dependencies.
package alu8_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned OP_W   = 4;

   typedef logic [DATA_W-1:0] data_type;

   // Codes nine to fifteen are unused and fall to the default arm.
   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_CMP  = 4'd2,
      OP_AND  = 4'd3,
      OP_OR   = 4'd4,
      OP_XOR  = 4'd5,
      OP_INC  = 4'd6,
      OP_DEC  = 4'd7,
      OP_MOVE = 4'd8
   } opcode_type;

   typedef struct packed {
      logic v;
      logic c;
      logic n;
      logic z;
   } flags_type;

   typedef struct packed {
      data_type  value;
      logic      written;
      flags_type flags;
   } result_type;

endpackage

// ----- sv/alu8_if.sv -----
// Channel interfaces for the eight-bit ALU: request and response.
// Depends on alu8_pkg.
interface alu8_req_if;
   import alu8_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       opcode;
   data_type              operand_a;
   data_type              operand_b;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input opcode, input operand_a, input operand_b,
                   output ready);
endinterface

interface alu8_rsp_if;
   import alu8_pkg::*;

   logic     valid;
   logic     ready;
   data_type result_value;
   logic     result_written;
   logic     zero_flag;
   logic     negative_flag;
   logic     carry_flag;
   logic     overflow_flag;

   modport source (output valid, output result_value, output result_written,
                   output zero_flag, output negative_flag, output carry_flag,
                   output overflow_flag, input ready);
   modport sink   (input valid, input result_value, input result_written,
                   input zero_flag, input negative_flag, input carry_flag,
                   input overflow_flag, output ready);
endinterface

// ----- sv/alu8_exec.sv -----
// Combinational execute unit of the eight-bit ALU.
// Computes the result and the updated flags from one request and the stored flags.
// Depends on alu8_pkg.
module alu8_exec (
   input  logic [alu8_pkg::OP_W-1:0] opcode,
   input  alu8_pkg::data_type        operand_a,
   input  alu8_pkg::data_type        operand_b,
   input  alu8_pkg::flags_type       flags_cur,
   output alu8_pkg::result_type      result
);
   import alu8_pkg::*;

   logic [DATA_W:0] sum_wide;
   logic [DATA_W:0] diff_wide;
   data_type        logic_res;
   logic            logic_op;
   logic            sign_a;
   logic            sign_b;

   assign sum_wide  = {1'b0, operand_a} + {1'b0, operand_b};
   assign diff_wide = {1'b0, operand_a} - {1'b0, operand_b};
   assign sign_a    = operand_a[DATA_W-1];
   assign sign_b    = operand_b[DATA_W-1];

   always_comb begin
      logic_res = '0;
      logic_op  = 1'b1;
      case (opcode_type'(opcode))
         OP_AND:  logic_res = operand_a & operand_b;
         OP_OR:   logic_res = operand_a | operand_b;
         OP_XOR:  logic_res = operand_a ^ operand_b;
         OP_INC:  logic_res = operand_a + data_type'(1);
         OP_DEC:  logic_res = operand_a - data_type'(1);
         OP_MOVE: logic_res = operand_a;
         default: logic_op  = 1'b0;
      endcase
   end

   always_comb begin
      result = '{value: '0, written: 1'b0, flags: flags_cur};
      if (opcode inside {OP_ADD}) begin
         result.value   = sum_wide[DATA_W-1:0];
         result.written = 1'b1;
         result.flags.z = (sum_wide[DATA_W-1:0] == '0);
         result.flags.n = sum_wide[DATA_W-1];
         result.flags.c = sum_wide[DATA_W];
         result.flags.v = (sign_a == sign_b) && (sum_wide[DATA_W-1] != sign_a);
      end else if (opcode inside {OP_SUB, OP_CMP}) begin
         // The ninth bit of the difference is the borrow, set when a < b.
         result.value   = diff_wide[DATA_W-1:0];
         result.written = (opcode_type'(opcode) == OP_SUB);
         result.flags.z = (diff_wide[DATA_W-1:0] == '0);
         result.flags.n = diff_wide[DATA_W-1];
         result.flags.c = diff_wide[DATA_W];
         result.flags.v = (sign_a != sign_b) && (diff_wide[DATA_W-1] != sign_a);
      end else if (logic_op) begin
         // Carry is kept; overflow is cleared.
         result.value   = logic_res;
         result.written = 1'b1;
         result.flags.z = (logic_res == '0);
         result.flags.n = logic_res[DATA_W-1];
         result.flags.v = 1'b0;
      end
   end

endmodule

// ----- sv/alu8_with_flags_core.sv -----
// Top level of the eight-bit ALU with Z, N, C and V flags.
// Depends on alu8_pkg, alu8_req_if, alu8_rsp_if and alu8_exec.
//
//   Channel   Modport   Payload                                       Handshake
//   req       sink      opcode, operand_a, operand_b                  valid/ready
//   rsp       source    result_value, result_written, Z, N, C, V      valid/ready
//
// A request is captured in the input register on the edge at which it is
// accepted, and its result is loaded into the result register when it
// advances. One request is accepted in every cycle while the response side
// keeps taking results; throughput is set by the single pass through the
// execute unit and the four-bit flag feedback.
// Reset clears both valid bits and the stored flags to zero.
// When the response is stalled the result register holds, the input register
// fills, and only then is req.ready dropped.
module alu8_with_flags_core (
   input logic    clock,
   input logic    reset,
   alu8_req_if.sink   req,
   alu8_rsp_if.source rsp
);
   import alu8_pkg::*;

   // Input register.
   logic                in_valid_ff, in_valid_in;
   logic [OP_W-1:0]     in_opcode_ff;
   data_type            in_a_ff;
   data_type            in_b_ff;

   // Result register and stored flags.
   logic                out_valid_ff, out_valid_in;
   result_type          out_ff;
   flags_type           flags_ff, flags_in;

   result_type          exec_res;
   logic                advance;
   logic                take_req;

   // The result register can be loaded when it is empty or being emptied;
   // the input register can take a request when it is empty or moving on.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || !out_valid_ff || rsp.ready;
   assign take_req = req.valid && req.ready;

   alu8_exec u_exec (
      .opcode    (in_opcode_ff),
      .operand_a (in_a_ff),
      .operand_b (in_b_ff),
      .flags_cur (flags_ff),
      .result    (exec_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      flags_in     = flags_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         flags_in     = exec_res.flags;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_opcode_ff <= req.opcode;
         in_a_ff      <= req.operand_a;
         in_b_ff      <= req.operand_b;
      end
      if (advance) begin
         out_ff <= exec_res;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.result_value   = out_ff.value;
   assign rsp.result_written = out_ff.written;
   assign rsp.zero_flag      = out_ff.flags.z;
   assign rsp.negative_flag  = out_ff.flags.n;
   assign rsp.carry_flag     = out_ff.flags.c;
   assign rsp.overflow_flag  = out_ff.flags.v;

   // A written result always reports its own zero and sign.
   a_zero_matches: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_written |-> rsp.zero_flag == (rsp.result_value == '0))
      else $error("zero flag disagrees with written result");

   a_sign_matches: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_written |-> rsp.negative_flag == rsp.result_value[DATA_W-1])
      else $error("negative flag disagrees with written result");

   // The flags shown with a pending result are the stored flags.
   a_flags_in_step: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> out_ff.flags == flags_ff)
      else $error("reported flags differ from stored flags");

   // Stored flags move only when a request passes through the execute unit.
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff))
      else $error("flags changed without an executed request");

   // An empty input register never refuses a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("request refused with empty input register");

endmodule

// ----- test/alu8_flags_checker.sv -----
// Checker for the eight-bit ALU: watches both channels, predicts each result
// and its flags, and compares in order. Depends on alu8_pkg.
module alu8_flags_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [alu8_pkg::OP_W-1:0]  req_opcode,
   input  alu8_pkg::data_type         req_operand_a,
   input  alu8_pkg::data_type         req_operand_b,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  alu8_pkg::data_type         rsp_result_value,
   input  logic                       rsp_result_written,
   input  logic                       rsp_zero_flag,
   input  logic                       rsp_negative_flag,
   input  logic                       rsp_carry_flag,
   input  logic                       rsp_overflow_flag,
   output int unsigned                mismatch_count,
   output int unsigned                results_outstanding,
   output int unsigned                results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import alu8_pkg::*;

   localparam int unsigned SIGN = DATA_W - 1;

   flags_type  model_flags;
   result_type pending_results[$];

   // Works out the result of one request from the flags held before it; the
   // flags field of the returned record is the new flag state.
   function automatic result_type predict_alu_result(input logic [OP_W-1:0] op,
                                                      input data_type a,
                                                      input data_type b,
                                                      input flags_type held);
      result_type       r;
      logic [DATA_W:0]  wide;
      r.value   = '0;
      r.written = 1'b1;
      r.flags   = held;
      case (op)
         OP_ADD: begin
            wide       = {1'b0, a} + {1'b0, b};
            r.value    = wide[DATA_W-1:0];
            r.flags.c  = wide[DATA_W];
            r.flags.v  = (a[SIGN] == b[SIGN]) && (r.value[SIGN] != a[SIGN]);
         end
         OP_SUB, OP_CMP: begin
            r.value    = a - b;
            r.flags.c  = (a < b);
            r.flags.v  = (a[SIGN] != b[SIGN]) && (r.value[SIGN] != a[SIGN]);
            r.written  = (op != OP_CMP);
         end
         OP_AND:  r.value = a & b;
         OP_OR:   r.value = a | b;
         OP_XOR:  r.value = a ^ b;
         OP_INC:  r.value = a + 1'b1;
         OP_DEC:  r.value = a - 1'b1;
         OP_MOVE: r.value = a;
         default: r.written = 1'b0;
      endcase
      if (op <= OP_MOVE) begin
         r.flags.z = (r.value == '0);
         r.flags.n = r.value[SIGN];
         if (op >= OP_AND)
            r.flags.v = 1'b0;
      end
      return r;
   endfunction

   initial begin
      mismatch_count      = 0;
      results_outstanding = 0;
      results_checked     = 0;
      model_flags         = '0;
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         pending_results.delete();
         model_flags = '0;
      end else begin
         // Results are retired before new requests are logged; a result can
         // never belong to a request accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            seen.value   = rsp_result_value;
            seen.written = rsp_result_written;
            seen.flags   = {rsp_overflow_flag, rsp_carry_flag, rsp_negative_flag,
                            rsp_zero_flag};
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: result with nothing expected: value %02h written %0b vczn %04b",
                           $realtime, seen.value, seen.written, seen.flags);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%t: result %0d: expected value %02h written %0b vczn %04b",
                              $realtime, results_checked, want.value, want.written,
                              want.flags);
                     $display("      got value %02h written %0b vczn %04b",
                              seen.value, seen.written, seen.flags);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want        = predict_alu_result(req_opcode, req_operand_a, req_operand_b,
                                             model_flags);
            model_flags = want.flags;
            pending_results.push_back(want);
         end
      end
      results_outstanding = pending_results.size();
   end

endmodule

// ----- test/tb_alu8_with_flags_core.sv -----
// Testbench top for alu8_with_flags_core: clock, reset, request stimulus and
// response stalls, with the verdict taken from alu8_flags_checker.
// Depends on alu8_pkg, alu8_req_if, alu8_rsp_if, alu8_with_flags_core and the checker.
module tb_alu8_with_flags_core;
   timeunit 1ns;
   timeprecision 1ps;

   import alu8_pkg::*;

   localparam int unsigned CLK_PERIOD    = 12;
   localparam int unsigned RANDOM_COUNT  = 1530;

   logic clock = 1'b0;
   logic reset;

   // When calm is set, neither side idles, so the block runs at full rate.
   bit          calm = 1'b0;
   int unsigned requests_sent  = 0;
   int unsigned directed_sent  = 0;
   int unsigned unused_sent    = 0;
   int unsigned mismatch_count;
   int unsigned results_outstanding;
   int unsigned results_checked;

   alu8_req_if req_ch ();
   alu8_rsp_if rsp_ch ();

   alu8_with_flags_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   alu8_flags_checker flag_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_opcode          (req_ch.opcode),
      .req_operand_a       (req_ch.operand_a),
      .req_operand_b       (req_ch.operand_b),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_result_value    (rsp_ch.result_value),
      .rsp_result_written  (rsp_ch.result_written),
      .rsp_zero_flag       (rsp_ch.zero_flag),
      .rsp_negative_flag   (rsp_ch.negative_flag),
      .rsp_carry_flag      (rsp_ch.carry_flag),
      .rsp_overflow_flag   (rsp_ch.overflow_flag),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding),
      .results_checked     (results_checked)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Length of an idle stretch on either side. More than half are empty;
   // now and then a long one lets the pipeline drain or fill completely.
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Operands lean towards the values at which carry, borrow and overflow
   // change, while still giving plenty of plain random bytes.
   function automatic data_type pick_operand();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h7F;
         3:       return 8'h80;
         4:       return 8'h01;
         default: return data_type'($urandom);
      endcase
   endfunction

   // Mostly the nine real operations; a small share of the unused codes,
   // which must leave the flags alone.
   function automatic logic [OP_W-1:0] pick_opcode();
      if ($urandom_range(0, 99) < 8)
         return (OP_W)'($urandom_range(OP_MOVE + 1, (1 << OP_W) - 1));
      return (OP_W)'($urandom_range(OP_ADD, OP_MOVE));
   endfunction

   // Presents one request after an optional idle stretch and holds it until
   // the block takes it. Valid is only lowered when there is a gap, so it is
   // never dropped and raised again within one time step.
   task automatic send_request(input logic [OP_W-1:0] op, input data_type a,
                               input data_type b);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      requests_sent++;
      if (op > OP_MOVE)
         unused_sent++;
   endtask

   // The response side takes results in bursts separated by stalls of the
   // same shape as the request gaps.
   initial begin : response_stalls
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin : stimulus
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OP_ADD;
      req_ch.operand_a <= '0;
      req_ch.operand_b <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests. The order matters: the carry is set by an add just
      // before the logic and step operations, so that keeping it is visible.
      send_request(OP_ADD, 8'h00, 8'h00);    // zero result, nothing else
      send_request(OP_ADD, 8'h7F, 8'h01);    // positive overflow into negative
      send_request(OP_ADD, 8'h80, 8'h80);    // carry, overflow and zero together
      send_request(OP_ADD, 8'hFF, 8'h01);    // carry out with zero result
      send_request(OP_AND, 8'hFF, 8'h0F);    // carry kept, overflow cleared
      send_request(OP_OR,  8'h00, 8'h00);    // zero from logic, carry still kept
      send_request(OP_XOR, 8'hFF, 8'hFF);
      send_request(OP_XOR, 8'hAA, 8'h55);    // negative from logic
      send_request(OP_INC, 8'hFF, 8'h00);    // increment wraps, carry untouched
      send_request(OP_INC, 8'h7F, 8'h00);
      send_request(OP_SUB, 8'h00, 8'h01);    // borrow, negative result
      send_request(OP_DEC, 8'h00, 8'h00);    // decrement wraps, borrow kept
      send_request(OP_DEC, 8'h01, 8'h00);
      send_request(OP_SUB, 8'h80, 8'h01);    // negative minus positive overflows
      send_request(OP_SUB, 8'h7F, 8'hFF);    // borrow and overflow at once
      send_request(OP_SUB, 8'hFF, 8'hFF);
      send_request(OP_CMP, 8'h05, 8'h05);    // equal: zero set, not written back
      send_request(OP_CMP, 8'h00, 8'hFF);    // borrow from compare
      send_request(OP_MOVE, 8'h80, 8'h00);
      send_request(OP_MOVE, 8'h00, 8'hFF);
      send_request(OP_ADD, 8'hC0, 8'h50);    // set carry before the unused codes
      send_request(OP_MOVE + 1'b1, 8'hFF, 8'hFF);  // lowest unused code
      send_request('1, 8'h00, 8'h00);              // highest unused code
      directed_sent = requests_sent;

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
         send_request(pick_opcode(), pick_operand(), pick_operand());
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      // Let the clock run on so that the checker has logged the last request,
      // then wait for every result to come back.
      @(posedge clock);
      wait (results_outstanding == 0);
      repeat (6) @(posedge clock);

      $display("Sent %0d requests (%0d directed, %0d with unused opcodes), checked %0d results,",
               requests_sent, directed_sent, unused_sent, results_checked);
      $display("with %0d mismatches and %0d results never returned.",
               mismatch_count, results_outstanding);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("tb_alu8_with_flags_core: done, clean");
      end else begin
         $display("tb_alu8_with_flags_core: done, errors");
      end
      $finish;
   end

   // Stops a run that has not finished by the time limit.
   initial begin : watchdog
      #10_000_000;
      $display("Timed out with %0d results still outstanding.", results_outstanding);
      $display("tb_alu8_with_flags_core: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
sv/alu8_pkg.sv
sv/alu8_if.sv
sv/alu8_exec.sv
sv/alu8_with_flags_core.sv
test/alu8_flags_checker.sv
test/tb_alu8_with_flags_core.sv
